// ===== hw/rtl/spk_pkg.sv =====
// Shared constants, types and register codes for the Speck 128 cipher block.
package spk_pkg;

	localparam int HALF_W        = 64;
	localparam int KEY_WORDS_MAX = 4;
	localparam int KW_W          = 3;
	localparam int BASE_ROUNDS   = 30;
	localparam int MAX_ROUNDS_DEF = 34;
	localparam int CFG_IDX_W     = 3;
	localparam int ROT_ALPHA     = 8;
	localparam int ROT_BETA      = 3;

	typedef logic [HALF_W-1:0] half_t;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_WORDS  = 3'd0,
		CFG_KEY_WORD_0 = 3'd1,
		CFG_KEY_WORD_1 = 3'd2,
		CFG_KEY_WORD_2 = 3'd3,
		CFG_KEY_WORD_3 = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KINIT,
		ST_EXPAND,
		ST_PREP,
		ST_ROUND,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/spk_in_if.sv =====
// Input block channel: opcode and the two block halves.
interface spk_in_if;
	import spk_pkg::*;

	logic  valid;
	logic  ready;
	op_t   opcode;
	half_t in_x;
	half_t in_y;

	modport source (output valid, opcode, in_x, in_y, input ready);
	modport sink   (input valid, opcode, in_x, in_y, output ready);
endinterface

// ===== hw/rtl/spk_out_if.sv =====
// Result block channel: the two transformed block halves.
interface spk_out_if;
	import spk_pkg::*;

	logic  valid;
	logic  ready;
	half_t out_x;
	half_t out_y;

	modport source (output valid, out_x, out_y, input ready);
	modport sink   (input valid, out_x, out_y, output ready);
endinterface

// ===== hw/rtl/spk_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface spk_cfg_if;
	import spk_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	half_t                data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/spk_round.sv =====
// Shared Speck round unit: one encrypt or one decrypt round per cycle.
module spk_round (
	input  logic          dec,
	input  spk_pkg::half_t x,
	input  spk_pkg::half_t y,
	input  spk_pkg::half_t k,
	output spk_pkg::half_t x_new,
	output spk_pkg::half_t y_new
);
	import spk_pkg::*;

	half_t enc_x;
	half_t enc_y;
	half_t dec_x;
	half_t dec_y;
	half_t dec_t;
	half_t dec_u;

	always_comb begin
		enc_x = ({x[ROT_ALPHA-1:0], x[HALF_W-1:ROT_ALPHA]} + y) ^ k;
		enc_y = {y[HALF_W-ROT_BETA-1:0], y[HALF_W-1:HALF_W-ROT_BETA]} ^ enc_x;
		dec_t = x ^ y;
		dec_y = {dec_t[ROT_BETA-1:0], dec_t[HALF_W-1:ROT_BETA]};
		dec_u = (x ^ k) - dec_y;
		dec_x = {dec_u[HALF_W-ROT_ALPHA-1:0], dec_u[HALF_W-1:HALF_W-ROT_ALPHA]};
	end

	assign x_new = dec ? dec_x : enc_x;
	assign y_new = dec ? dec_y : enc_y;
endmodule

// ===== hw/rtl/spk_rk_ram.sv =====
// Round key store: one write port, one read port with registered data.
module spk_rk_ram #(
	parameter int DEPTH = spk_pkg::MAX_ROUNDS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  spk_pkg::half_t wdata,
	input  logic [AW-1:0]  raddr,
	output spk_pkg::half_t rdata
);
	import spk_pkg::*;

	half_t mem [DEPTH];
	half_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hw/rtl/speck128_block_cipher_top.sv =====
// Speck 128 cipher top level: configuration, sequencer, key expansion and block rounds.
//
// Speck with a 128-bit block and a 2, 3 or 4 word (128, 192, 256-bit) key. One
// round unit serves both key expansion and the block rounds, one round per cycle,
// with round keys kept in a single-port-read RAM. A block is accepted, its first
// round key is fetched, it runs 30+m rounds and its result is handed off. After
// reset or after a write to the key word count or to a key word register, the
// next accepted block first expands the key. The block accepts one block at a
// time; a finished result waits in an output register while the next block is
// taken in. Configuration writes are taken only while idle, and a pending write
// holds off a block offered in the same cycle.
module speck128_block_cipher_top #(
	parameter int MAX_ROUNDS = spk_pkg::MAX_ROUNDS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	spk_in_if.sink    blk,
	spk_out_if.source res,
	spk_cfg_if.sink   cfg
);
	import spk_pkg::*;

	localparam int CNT_W = $clog2(MAX_ROUNDS);

	state_t            state_q;
	state_t            state_d;
	logic [KW_W-1:0]   key_words_q;
	half_t             key_word_q [KEY_WORDS_MAX];
	logic              sched_ok_q;
	logic [CNT_W-1:0]  cnt_q;
	op_t               op_q;
	half_t             x_q;
	half_t             y_q;
	half_t             k_q;
	half_t             l_q [KEY_WORDS_MAX-1];
	logic              out_valid_q;
	half_t             ox_q;
	half_t             oy_q;

	logic [KW_W-1:0]   m_w;
	logic [CNT_W:0]    rounds_w;
	logic [CNT_W-1:0]  last_idx;
	logic              round_done;
	logic              expand_done;
	logic              in_acc;
	logic              cfg_acc;

	logic              in_ready;
	logic              cfg_ready;
	logic              ram_we;
	logic [CNT_W-1:0]  ram_waddr;
	half_t             ram_wdata;
	logic [CNT_W-1:0]  ram_raddr;
	half_t             ram_rdata;
	logic              ru_exp;
	logic              out_load;

	half_t             ru_x;
	half_t             ru_y;
	half_t             ru_k;
	logic              ru_dec;
	half_t             ru_x_new;
	half_t             ru_y_new;

	always_comb begin
		if (key_words_q < KW_W'(2)) begin
			m_w = KW_W'(2);
		end else if (key_words_q > KW_W'(KEY_WORDS_MAX)) begin
			m_w = KW_W'(KEY_WORDS_MAX);
		end else begin
			m_w = key_words_q;
		end
		rounds_w = (CNT_W+1)'(BASE_ROUNDS) + (CNT_W+1)'(m_w);
		if (rounds_w > (CNT_W+1)'(MAX_ROUNDS)) begin
			rounds_w = (CNT_W+1)'(MAX_ROUNDS);
		end
		last_idx = CNT_W'(rounds_w - 1'b1);
	end

	assign in_acc      = blk.valid && in_ready;
	assign cfg_acc     = cfg.valid && cfg_ready;
	assign expand_done = (cnt_q == last_idx - 1'b1);
	assign round_done  = (op_q == OP_DECRYPT) ? (cnt_q == '0) : (cnt_q == last_idx);

	assign blk.ready = in_ready;
	assign cfg.ready = cfg_ready;
	assign res.valid = out_valid_q;
	assign res.out_x = ox_q;
	assign res.out_y = oy_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = sched_ok_q ? ST_PREP : ST_KINIT;
				end
			end
			ST_KINIT:  state_d = ST_EXPAND;
			ST_EXPAND: begin
				if (expand_done) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP:   state_d = ST_ROUND;
			ST_ROUND: begin
				if (round_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || res.ready) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cnt_q + 1'b1;
		ram_wdata = ru_y_new;
		ram_raddr = cnt_q;
		ru_exp    = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = !cfg.valid;
				cfg_ready = 1'b1;
			end
			ST_KINIT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = key_word_q[2'(m_w - 1'b1)];
			end
			ST_EXPAND: begin
				ram_we = 1'b1;
				ru_exp = 1'b1;
			end
			ST_PREP: begin
				ram_raddr = (op_q == OP_DECRYPT) ? last_idx : '0;
			end
			ST_ROUND: begin
				if (round_done) begin
					ram_raddr = cnt_q;
				end else if (op_q == OP_DECRYPT) begin
					ram_raddr = cnt_q - 1'b1;
				end else begin
					ram_raddr = cnt_q + 1'b1;
				end
			end
			ST_DONE: begin
				out_load = !out_valid_q || res.ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign ru_dec = ru_exp ? 1'b0 : (op_q == OP_DECRYPT);
	assign ru_x   = ru_exp ? l_q[0] : x_q;
	assign ru_y   = ru_exp ? k_q : y_q;
	assign ru_k   = ru_exp ? HALF_W'(cnt_q) : ram_rdata;

	spk_round u_round (
		.dec   (ru_dec),
		.x     (ru_x),
		.y     (ru_y),
		.k     (ru_k),
		.x_new (ru_x_new),
		.y_new (ru_y_new)
	);

	spk_rk_ram #(
		.DEPTH (MAX_ROUNDS),
		.AW    (CNT_W)
	) u_rk_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_words_q <= KW_W'(KEY_WORDS_MAX);
			for (int i = 0; i < KEY_WORDS_MAX; i++) begin
				key_word_q[i] <= '0;
			end
			sched_ok_q  <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_acc) begin
				case (cfg_idx_t'(cfg.index))
					CFG_KEY_WORDS: begin
						key_words_q <= cfg.data[KW_W-1:0];
						sched_ok_q  <= 1'b0;
					end
					CFG_KEY_WORD_0: begin
						key_word_q[0] <= cfg.data;
						sched_ok_q    <= 1'b0;
					end
					CFG_KEY_WORD_1: begin
						key_word_q[1] <= cfg.data;
						sched_ok_q    <= 1'b0;
					end
					CFG_KEY_WORD_2: begin
						key_word_q[2] <= cfg.data;
						sched_ok_q    <= 1'b0;
					end
					CFG_KEY_WORD_3: begin
						key_word_q[3] <= cfg.data;
						sched_ok_q    <= 1'b0;
					end
					default: begin
						sched_ok_q <= sched_ok_q;
					end
				endcase
			end
			case (state_q)
				ST_KINIT:  cnt_q <= '0;
				ST_EXPAND: begin
					cnt_q <= cnt_q + 1'b1;
					if (expand_done) begin
						sched_ok_q <= 1'b1;
					end
				end
				ST_PREP:   cnt_q <= (op_q == OP_DECRYPT) ? last_idx : '0;
				ST_ROUND: begin
					if (!round_done) begin
						cnt_q <= (op_q == OP_DECRYPT) ? cnt_q - 1'b1 : cnt_q + 1'b1;
					end
				end
				default:   cnt_q <= cnt_q;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q <= blk.opcode;
			x_q  <= blk.in_x;
			y_q  <= blk.in_y;
		end
		if (state_q == ST_ROUND) begin
			x_q <= ru_x_new;
			y_q <= ru_y_new;
		end
		if (state_q == ST_KINIT) begin
			case (m_w)
				KW_W'(2): begin
					k_q    <= key_word_q[1];
					l_q[0] <= key_word_q[0];
				end
				KW_W'(3): begin
					k_q    <= key_word_q[2];
					l_q[0] <= key_word_q[1];
					l_q[1] <= key_word_q[0];
				end
				default: begin
					k_q    <= key_word_q[3];
					l_q[0] <= key_word_q[2];
					l_q[1] <= key_word_q[1];
					l_q[2] <= key_word_q[0];
				end
			endcase
		end
		if (state_q == ST_EXPAND) begin
			k_q    <= ru_y_new;
			l_q[0] <= (m_w == KW_W'(2)) ? ru_x_new : l_q[1];
			l_q[1] <= (m_w == KW_W'(3)) ? ru_x_new : l_q[2];
			l_q[2] <= ru_x_new;
		end
		if (out_load) begin
			ox_q <= x_q;
			oy_q <= y_q;
		end
	end
endmodule
